FILE: rtl/core/lsqc_pkg.sv
// Shared types, constants and command/status bundles for the load-slice classifier.
`default_nettype none
package lsqc_pkg;

  localparam int WAYS     = 2;
  localparam int ENTRIES  = 128;
  localparam int NUM_REGS = 64;

  localparam int IP_W    = 48;
  localparam int REGF_W  = 7;
  localparam int TAG_W   = 32;
  localparam int AGE_W   = 64;
  localparam int SET_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SET_SH  = $clog2(ENTRIES);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int REG_W   = $clog2(NUM_REGS);
  localparam int MODE_W  = 3;
  localparam int CLS_W   = 2;

  localparam logic [REGF_W-1:0] REG_NONE = 7'd64;

  localparam logic [MODE_W-1:0] MODE_PREDICT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STORE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OTHER   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  localparam logic [CLS_W-1:0] CLS_MAIN = 2'd0;
  localparam logic [CLS_W-1:0] CLS_AGQ  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LQ   = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic       load_item;
    logic       prod_wr;
    logic       dst_sel;
    logic       prod_rd;
    logic [1:0] src_sel;
    logic       addr_from_prod;
    logic       slice_rd;
    logic       slice_wr;
    logic       pred_cmp;
    logic       clr_prod;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              stop_train;
    logic [2:0]        src_ok;
    logic              out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/lsqc_dp.sv
// Datapath: item registers, producer table, slice table, use counter, result word.
`default_nettype none
module lsqc_dp (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire lsqc_pkg::cmd_t           cmd,
  output lsqc_pkg::stat_t               stat,
  input  wire [2:0]                     in_mode,
  input  wire [47:0]                    in_ip,
  input  wire                           in_is_load,
  input  wire                           in_is_barrier,
  input  wire                           in_in_main_queue,
  input  wire [6:0]                     in_src_reg_a,
  input  wire [6:0]                     in_src_reg_b,
  input  wire [6:0]                     in_src_reg_c,
  input  wire [6:0]                     in_dst_reg_a,
  input  wire [6:0]                     in_dst_reg_b,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [1:0]                    out_queue_class,
  output logic                          out_done_res
);
  import lsqc_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              is_load_r, is_bar_r, main_r;
  logic [REGF_W-1:0] src_r [3];
  logic [REGF_W-1:0] dst_a_r, dst_b_r;
  logic [IP_W-1:0]   addr_r;

  logic [IP_W-1:0]     prod_mem [NUM_REGS];
  logic [NUM_REGS-1:0] prod_vld_r;
  logic [IP_W-1:0]     prod_q_r;

  row_t               slice_mem [ENTRIES];
  logic [ENTRIES-1:0] row_vld_r;
  row_t               row_q_r;
  logic               rowv_q_r;
  logic [AGE_W-1:0]   cnt_r;
  logic [CLS_W-1:0]   cls_r;
  logic               out_valid_r;
  logic [CLS_W-1:0]   out_cls_r;

  logic [SET_W-1:0] set_idx;
  logic [TAG_W-1:0] tag;
  row_t             row_eff, row_new;
  logic             hit;
  logic [WAY_W-1:0] hit_way, victim, wsel;
  logic [REGF_W-1:0] dst_cur, src_cur;
  logic [2:0]        src_ok;

  function automatic logic usable(input logic [REGF_W-1:0] r);
    usable = (r != REG_NONE) && ({1'b0, r} < (REGF_W+1)'(NUM_REGS));
  endfunction

  assign set_idx = addr_r[SET_W-1:0];
  assign tag     = addr_r[SET_SH +: TAG_W];
  assign row_eff = rowv_q_r ? row_q_r : '0;
  assign dst_cur = cmd.dst_sel ? dst_b_r : dst_a_r;
  assign src_cur = (cmd.src_sel == 2'd0) ? src_r[0] :
                   (cmd.src_sel == 2'd1) ? src_r[1] : src_r[2];

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    victim  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row_eff[w].tag == tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (row_eff[w].age < row_eff[victim].age) victim = WAY_W'(w);
    end
    wsel = hit ? hit_way : victim;
    row_new = row_eff;
    row_new[wsel].tag = tag;
    row_new[wsel].age = cnt_r;
  end

  always_comb begin
    for (int k = 0; k < 3; k++)
      src_ok[k] = usable(src_r[k]) && prod_vld_r[src_r[k][REG_W-1:0]];
  end

  assign stat.mode       = mode_r;
  assign stat.stop_train = main_r | is_bar_r;
  assign stat.src_ok     = src_ok;
  assign stat.out_free   = !out_valid_r || !out_stall;

  // item word
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r    <= in_mode;
      is_load_r <= in_is_load;
      is_bar_r  <= in_is_barrier;
      main_r    <= in_in_main_queue;
      src_r[0]  <= in_src_reg_a;
      src_r[1]  <= in_src_reg_b;
      src_r[2]  <= in_src_reg_c;
      dst_a_r   <= in_dst_reg_a;
      dst_b_r   <= in_dst_reg_b;
      addr_r    <= in_ip;
    end else if (cmd.addr_from_prod) begin
      addr_r <= prod_q_r;
    end
  end

  // producer table
  always_ff @(posedge clk) begin
    if (cmd.prod_wr && usable(dst_cur)) prod_mem[dst_cur[REG_W-1:0]] <= addr_r;
    if (cmd.prod_rd) prod_q_r <= prod_mem[src_cur[REG_W-1:0]];
  end

  // slice table rows
  always_ff @(posedge clk) begin
    if (cmd.slice_wr) slice_mem[set_idx] <= row_new;
    if (cmd.slice_rd) row_q_r <= slice_mem[set_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r  <= '0;
      row_vld_r   <= '0;
      rowv_q_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_prod) prod_vld_r <= '0;
      else if (cmd.prod_wr && usable(dst_cur)) prod_vld_r[dst_cur[REG_W-1:0]] <= 1'b1;
      if (cmd.slice_rd) rowv_q_r <= row_vld_r[set_idx];
      if (cmd.slice_wr) begin
        row_vld_r[set_idx] <= 1'b1;
        cnt_r              <= cnt_r + 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) cls_r <= CLS_MAIN;
    else if (cmd.pred_cmp)
      cls_r <= (is_load_r || is_bar_r) ? CLS_LQ : (hit ? CLS_AGQ : CLS_MAIN);
    if (cmd.out_load) out_cls_r <= cls_r;
  end

  assign out_valid       = out_valid_r;
  assign out_queue_class = out_cls_r;
  assign out_done_res    = 1'b1;

endmodule
`default_nettype wire

FILE: rtl/core/lsqc_ctrl.sv
// Controller: sequences producer and slice-table steps for one item at a time.
`default_nettype none
module lsqc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire [2:0]           in_mode,
  output logic                in_stall,
  input  wire lsqc_pkg::stat_t stat,
  output lsqc_pkg::cmd_t      cmd
);
  import lsqc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DSTA = 4'd1;
  localparam logic [3:0] S_DSTB = 4'd2;
  localparam logic [3:0] S_SRCK = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_LAT  = 4'd5;
  localparam logic [3:0] S_TRD  = 4'd6;
  localparam logic [3:0] S_TWR  = 4'd7;
  localparam logic [3:0] S_PCMP = 4'd8;
  localparam logic [3:0] S_CLR  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       ip_pass_r, ip_pass_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    ip_pass_nxt = ip_pass_r;
    cmd         = '0;
    cmd.src_sel = k_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          k_nxt         = 2'd0;
          ip_pass_nxt   = 1'b0;
          case (in_mode)
            MODE_PREDICT:          state_nxt = S_TRD;
            MODE_STORE, MODE_LOAD: state_nxt = S_SRCK;
            MODE_OTHER:            state_nxt = S_DSTA;
            MODE_CLEAR:            state_nxt = S_CLR;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_DSTA: begin
        cmd.prod_wr = 1'b1;
        state_nxt   = S_DSTB;
      end
      S_DSTB: begin
        cmd.prod_wr = 1'b1;
        cmd.dst_sel = 1'b1;
        if (stat.stop_train) state_nxt = S_DONE;
        else begin
          ip_pass_nxt = 1'b1;
          state_nxt   = S_TRD;
        end
      end
      S_SRCK: begin
        if (k_r == 2'd3) state_nxt = S_DONE;
        else if (stat.src_ok[k_r]) state_nxt = S_PRD;
        else k_nxt = k_r + 2'd1;
      end
      S_PRD: begin
        cmd.prod_rd = 1'b1;
        state_nxt   = S_LAT;
      end
      S_LAT: begin
        cmd.addr_from_prod = 1'b1;
        state_nxt          = S_TRD;
      end
      S_TRD: begin
        cmd.slice_rd = 1'b1;
        state_nxt    = (stat.mode == MODE_PREDICT) ? S_PCMP : S_TWR;
      end
      S_TWR: begin
        cmd.slice_wr = 1'b1;
        // the ip's own touch comes before the sources
        if (ip_pass_r) ip_pass_nxt = 1'b0;
        else k_nxt = k_r + 2'd1;
        state_nxt = S_SRCK;
      end
      S_PCMP: begin
        cmd.pred_cmp = 1'b1;
        state_nxt    = S_DONE;
      end
      S_CLR: begin
        cmd.clr_prod = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= 2'd0;
      ip_pass_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      ip_pass_r <= ip_pass_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/load_slice_queue_classifier_core.sv
// Top level of the load-slice queue classifier.
`default_nettype none
// Steers micro-ops to the main, address-generation or load queue using a
// set-associative slice table (LRU by a shared 64-bit use counter) and a
// per-register last-producer table. One word is taken at a time: a predict
// reads the slice table and compares, a clear empties the producer table,
// an unused mode only returns a result, a store/load trains the table for
// each valid source producer, and an other-op records its destinations and,
// unless it stops there, trains its ip and then its valid sources; a result
// waits while the previous one is stalled. Each table touch is a registered row read
// followed by a read-modify-write of the slice table's single row port.
// The next word is accepted while a result waits in the output register.
module load_slice_queue_classifier_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [2:0]  in_mode,
  input  wire [47:0] in_ip,
  input  wire        in_is_load,
  input  wire        in_is_barrier,
  input  wire        in_in_main_queue,
  input  wire [6:0]  in_src_reg_a,
  input  wire [6:0]  in_src_reg_b,
  input  wire [6:0]  in_src_reg_c,
  input  wire [6:0]  in_dst_reg_a,
  input  wire [6:0]  in_dst_reg_b,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_queue_class,
  output logic       out_done_res
);
  import lsqc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lsqc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsqc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_ip            (in_ip),
    .in_is_load       (in_is_load),
    .in_is_barrier    (in_is_barrier),
    .in_in_main_queue (in_in_main_queue),
    .in_src_reg_a     (in_src_reg_a),
    .in_src_reg_b     (in_src_reg_b),
    .in_src_reg_c     (in_src_reg_c),
    .in_dst_reg_a     (in_dst_reg_a),
    .in_dst_reg_b     (in_dst_reg_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_queue_class  (out_queue_class),
    .out_done_res     (out_done_res)
  );

endmodule
`default_nettype wire
